FILE: rtl/core/gea_pkg.sv
// gea_pkg: shared types and constants for the grid earliest-arrival search
// no dependencies; used by gea_heap and grid_earliest_arrival_dijkstra_unit
`default_nettype none

package gea_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int OUT_W      = 21;
    localparam logic [OUT_W-1:0] OUT_MAX = 21'h1FFFFF;

    // neighbour step codes
    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_CHK_A,
        S_CHK_B,
        S_CHK_C,
        S_POP,
        S_POP_W,
        S_VIS,
        S_NB,
        S_NB_CHK,
        S_PUSH_W,
        S_DONE
    } ctl_state_t;

    typedef enum logic [2:0] {
        H_IDLE,
        H_UP,
        H_UP_CMP,
        H_POP_TOP,
        H_POP_LAST,
        H_DN,
        H_DN_L,
        H_DN_R
    } heap_state_t;

    // requests from the controller to the heap
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } heap_ctl_t;

    // heap status back to the controller
    typedef struct packed {
        logic busy;
        logic empty;
    } heap_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/gea_heap.sv
// gea_heap: binary min-heap in a single-port-read memory, hole-based sift
// depends on gea_pkg (heap_ctl_t, heap_sts_t, heap_state_t)
`default_nettype none

module gea_heap #(
    parameter int DEPTH = 262144,
    parameter int TM_W  = 38,
    parameter int ENT_W = 54
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  gea_pkg::heap_ctl_t     ctl,
    input  wire  [ENT_W-1:0]       push_ent,
    output gea_pkg::heap_sts_t     sts,
    output logic [ENT_W-1:0]       top_ent
);

    localparam int HI_W = $clog2(DEPTH);
    localparam int HC_W = $clog2(DEPTH + 1);
    localparam int XI_W = HI_W + 2;

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd_q;
    logic [HI_W-1:0]  rd_addr;
    logic             wr_en;
    logic [HI_W-1:0]  wr_addr;
    logic [ENT_W-1:0] wr_data;

    gea_pkg::heap_state_t state_reg, state_next;
    logic [HC_W-1:0]  count_reg, count_next;
    logic [HI_W-1:0]  hole_reg, hole_next;
    logic [ENT_W-1:0] item_reg, item_next;
    logic [ENT_W-1:0] top_reg, top_next;
    logic [ENT_W-1:0] left_reg, left_next;

    logic [XI_W-1:0]  l_idx, r_idx, cnt_x;
    logic [HI_W-1:0]  parent;
    logic [ENT_W-1:0] left_cur;
    logic [ENT_W-1:0] best;
    logic [HI_W-1:0]  best_idx;
    logic             moved;

    // heap memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gea_pkg::H_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        hole_reg <= hole_next;
        item_reg <= item_next;
        top_reg  <= top_next;
        left_reg <= left_next;
    end

    // child and parent indexes of the hole
    assign l_idx  = {1'b0, hole_reg, 1'b1};
    assign r_idx  = l_idx + XI_W'(1);
    assign cnt_x  = XI_W'(count_reg);
    assign parent = HI_W'((hole_reg - HI_W'(1)) >> 1);

    // left child: fresh from memory in the first compare, held after
    assign left_cur = (state_reg == gea_pkg::H_DN_L) ? rd_q : left_reg;

    // sequencer for push and pop
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        hole_next  = hole_reg;
        item_next  = item_reg;
        top_next   = top_reg;
        left_next  = left_reg;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = hole_reg;
        wr_data    = item_reg;
        best       = item_reg;
        best_idx   = hole_reg;
        moved      = 1'b0;
        case (state_reg)
            gea_pkg::H_IDLE: begin
                if (ctl.clear) begin
                    count_next = '0;
                end else if (ctl.push) begin
                    if (32'(count_reg) < DEPTH) begin
                        hole_next  = HI_W'(count_reg);
                        item_next  = push_ent;
                        count_next = count_reg + HC_W'(1);
                        state_next = gea_pkg::H_UP;
                    end
                end else if (ctl.pop && count_reg != '0) begin
                    rd_addr    = '0;
                    count_next = count_reg - HC_W'(1);
                    state_next = gea_pkg::H_POP_TOP;
                end
            end
            gea_pkg::H_UP: begin
                if (hole_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = gea_pkg::H_IDLE;
                end else begin
                    rd_addr    = parent;
                    state_next = gea_pkg::H_UP_CMP;
                end
            end
            gea_pkg::H_UP_CMP: begin
                wr_en = 1'b1;
                if (rd_q[ENT_W-1 -: TM_W] <= item_reg[ENT_W-1 -: TM_W]) begin
                    state_next = gea_pkg::H_IDLE;
                end else begin
                    wr_data    = rd_q;
                    hole_next  = parent;
                    state_next = gea_pkg::H_UP;
                end
            end
            gea_pkg::H_POP_TOP: begin
                top_next = rd_q;
                rd_addr  = HI_W'(count_reg);
                if (count_reg == '0) begin
                    state_next = gea_pkg::H_IDLE;
                end else begin
                    state_next = gea_pkg::H_POP_LAST;
                end
            end
            gea_pkg::H_POP_LAST: begin
                item_next  = rd_q;
                hole_next  = '0;
                state_next = gea_pkg::H_DN;
            end
            gea_pkg::H_DN: begin
                if (l_idx >= cnt_x) begin
                    wr_en      = 1'b1;
                    state_next = gea_pkg::H_IDLE;
                end else begin
                    rd_addr    = HI_W'(l_idx);
                    state_next = gea_pkg::H_DN_L;
                end
            end
            gea_pkg::H_DN_L, gea_pkg::H_DN_R: begin
                // pick the smallest of item, left and (if present) right
                if (state_reg == gea_pkg::H_DN_L) begin
                    left_next = rd_q;
                end
                if (left_cur[ENT_W-1 -: TM_W] < item_reg[ENT_W-1 -: TM_W]) begin
                    best     = left_cur;
                    best_idx = HI_W'(l_idx);
                    moved    = 1'b1;
                end
                if (state_reg == gea_pkg::H_DN_R &&
                    rd_q[ENT_W-1 -: TM_W] < best[ENT_W-1 -: TM_W]) begin
                    best     = rd_q;
                    best_idx = HI_W'(r_idx);
                    moved    = 1'b1;
                end
                if (state_reg == gea_pkg::H_DN_L && r_idx < cnt_x) begin
                    rd_addr    = HI_W'(r_idx);
                    state_next = gea_pkg::H_DN_R;
                end else begin
                    wr_en = 1'b1;
                    if (moved) begin
                        wr_data    = best;
                        hole_next  = best_idx;
                        state_next = gea_pkg::H_DN;
                    end else begin
                        state_next = gea_pkg::H_IDLE;
                    end
                end
            end
            default: begin
                state_next = gea_pkg::H_IDLE;
            end
        endcase
    end

    assign sts.busy  = state_reg != gea_pkg::H_IDLE;
    assign sts.empty = count_reg == '0;
    assign top_ent   = top_reg;

endmodule

`default_nettype wire

FILE: rtl/core/grid_earliest_arrival_dijkstra_unit.sv
// grid_earliest_arrival_dijkstra_unit: grid store, visited map and search sequencer
// depends on gea_pkg and gea_heap
//
//  channel | ports                              | role
//  --------+------------------------------------+------------------------------
//  cfg     | cfg_valid/ready, cfg_index, data   | rows and cols registers
//  s_      | s_valid/ready, s_func, s_cell_time | load a cell or start a run
//  m_      | m_valid/ready, m_reachable, ...    | one result item per run
//
// a load item is written to the grid store as it is accepted. a run clears
// the used part of the visited map and reads the two start neighbours, then
// pops cells and pushes up to four neighbours of each; the shared heap memory
// port sets the pace. reset is synchronous, active low. s_ready stays low for
// a whole run, and a finished run waits in S_DONE while the previous result
// is still unread.
`default_nettype none

module grid_earliest_arrival_dijkstra_unit #(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_COLS   = 256,
    parameter int HEAP_DEPTH = 262144,
    parameter int TIME_BITS  = 20
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [gea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [gea_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire                            s_func,
    input  wire  [TIME_BITS-1:0]           s_cell_time,
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic                           m_reachable,
    output logic [gea_pkg::OUT_W-1:0]      m_min_time
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int GA_W  = RW + CW;
    localparam int TM_W  = TIME_BITS + GA_W + 2;
    localparam int ENT_W = TM_W + GA_W;
    localparam int SW    = TM_W + gea_pkg::OUT_W;
    localparam int OW    = gea_pkg::OUT_W;

    // grid and visited memories
    logic [TIME_BITS-1:0] grid_mem [2**GA_W];
    logic                 vis_mem  [2**GA_W];
    logic                 grid_we;
    logic [GA_W-1:0]      grid_wa, grid_ra, vis_wa, vis_ra;
    logic [TIME_BITS-1:0] grid_q;
    logic                 vis_we, vis_wd, vis_q;

    always_ff @(posedge aclk) begin
        if (grid_we) begin
            grid_mem[grid_wa] <= s_cell_time;
        end
        grid_q <= grid_mem[grid_ra];
    end

    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_wa] <= vis_wd;
        end
        vis_q <= vis_mem[vis_ra];
    end

    gea_pkg::ctl_state_t state_reg, state_next;
    logic [gea_pkg::CFG_DATA_W-1:0] rows_reg, cols_reg;
    logic [RW-1:0]   ld_r_reg, ld_r_next, cr_reg, cr_next, nr_reg, nr_next;
    logic [CW-1:0]   ld_c_reg, ld_c_next, cc_reg, cc_next, nc_reg, nc_next;
    logic [RW-1:0]   clr_r_reg, clr_r_next;
    logic [CW-1:0]   clr_c_reg, clr_c_next;
    logic [TM_W-1:0] ct_reg, ct_next;
    logic [TIME_BITS-1:0] chk_reg, chk_next;
    logic [1:0]      dir_reg, dir_next;
    logic            res_ok_reg, res_ok_next;
    logic [OW-1:0]   res_t_reg, res_t_next;
    logic            mv_reg, mv_next, mr_reg, mr_next;
    logic [OW-1:0]   mt_reg, mt_next;

    logic [RW-1:0]   last_r;
    logic [CW-1:0]   last_c;
    logic [CW:0]     ncols;
    logic [TM_W-1:0] arr1, need, arr;
    logic [SW-1:0]   t_wide;
    logic            nb_ok;
    logic [RW-1:0]   nb_r;
    logic [CW-1:0]   nb_c;

    gea_pkg::heap_ctl_t hctl;
    gea_pkg::heap_sts_t hsts;
    logic [ENT_W-1:0]   push_ent, top_ent;

    gea_heap #(
        .DEPTH (HEAP_DEPTH),
        .TM_W  (TM_W),
        .ENT_W (ENT_W)
    ) u_heap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (hctl),
        .push_ent (push_ent),
        .sts      (hsts),
        .top_ent  (top_ent)
    );

    // row-major grid address of a cell
    function automatic logic [GA_W-1:0] lin_addr(logic [RW-1:0] r, logic [CW-1:0] c,
                                                 logic [CW:0] nc);
        logic [RW+CW:0] p;
        p = (RW+CW+1)'(r) * (RW+CW+1)'(nc) + (RW+CW+1)'(c);
        return GA_W'(p);
    endfunction

    // effective last row and column, clamped to the supported range
    always_comb begin
        if (rows_reg < gea_pkg::CFG_DATA_W'(2)) begin
            last_r = RW'(1);
        end else if (32'(rows_reg) > MAX_ROWS) begin
            last_r = RW'(MAX_ROWS - 1);
        end else begin
            last_r = RW'(32'(rows_reg) - 1);
        end
        if (cols_reg < gea_pkg::CFG_DATA_W'(2)) begin
            last_c = CW'(1);
        end else if (32'(cols_reg) > MAX_COLS) begin
            last_c = CW'(MAX_COLS - 1);
        end else begin
            last_c = CW'(32'(cols_reg) - 1);
        end
    end

    assign ncols = (CW+1)'(last_c) + (CW+1)'(1);

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= gea_pkg::CFG_DATA_W'(2);
            cols_reg <= gea_pkg::CFG_DATA_W'(2);
        end else if (cfg_valid) begin
            if (cfg_index == gea_pkg::REG_ROWS) begin
                rows_reg <= cfg_data;
            end else if (cfg_index == gea_pkg::REG_COLS) begin
                cols_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gea_pkg::S_IDLE;
            ld_r_reg  <= '0;
            ld_c_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ld_r_reg  <= ld_r_next;
            ld_c_reg  <= ld_c_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cr_reg     <= cr_next;
        cc_reg     <= cc_next;
        nr_reg     <= nr_next;
        nc_reg     <= nc_next;
        clr_r_reg  <= clr_r_next;
        clr_c_reg  <= clr_c_next;
        ct_reg     <= ct_next;
        chk_reg    <= chk_next;
        dir_reg    <= dir_next;
        res_ok_reg <= res_ok_next;
        res_t_reg  <= res_t_next;
        mr_reg     <= mr_next;
        mt_reg     <= mt_next;
    end

    // neighbour of the current cell in the current direction
    always_comb begin
        nb_ok = 1'b0;
        nb_r  = cr_reg;
        nb_c  = cc_reg;
        case (dir_reg)
            gea_pkg::DIR_DOWN: begin
                nb_ok = cr_reg < last_r;
                nb_r  = cr_reg + RW'(1);
            end
            gea_pkg::DIR_UP: begin
                nb_ok = cr_reg != '0;
                nb_r  = cr_reg - RW'(1);
            end
            gea_pkg::DIR_RIGHT: begin
                nb_ok = cc_reg < last_c;
                nb_c  = cc_reg + CW'(1);
            end
            gea_pkg::DIR_LEFT: begin
                nb_ok = cc_reg != '0;
                nb_c  = cc_reg - CW'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // arrival time with the even-parity wait
    assign arr1 = ct_reg + TM_W'(1);
    assign need = TM_W'(grid_q);
    assign arr  = (arr1 < need) ? need + TM_W'((need[0] ^ arr1[0])) : arr1;
    assign t_wide = SW'(top_ent[ENT_W-1 -: TM_W]);

    // search sequencer
    always_comb begin
        state_next  = state_reg;
        ld_r_next   = ld_r_reg;
        ld_c_next   = ld_c_reg;
        cr_next     = cr_reg;
        cc_next     = cc_reg;
        nr_next     = nr_reg;
        nc_next     = nc_reg;
        clr_r_next  = clr_r_reg;
        clr_c_next  = clr_c_reg;
        ct_next     = ct_reg;
        chk_next    = chk_reg;
        dir_next    = dir_reg;
        res_ok_next = res_ok_reg;
        res_t_next  = res_t_reg;
        mv_next     = mv_reg;
        mr_next     = mr_reg;
        mt_next     = mt_reg;
        s_ready     = 1'b0;
        grid_we     = 1'b0;
        grid_wa     = lin_addr(ld_r_reg, ld_c_reg, ncols);
        grid_ra     = lin_addr(nb_r, nb_c, ncols);
        vis_we      = 1'b0;
        vis_wa      = {clr_r_reg, clr_c_reg};
        vis_wd      = 1'b0;
        vis_ra      = {nb_r, nb_c};
        hctl        = '0;
        push_ent    = {arr, nr_reg, nc_reg};

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        if (cfg_valid) begin
            ld_r_next = '0;
            ld_c_next = '0;
        end

        case (state_reg)
            gea_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && !s_func) begin
                    // load one cell, row-major with wrap after the last cell
                    grid_we = 1'b1;
                    if (ld_c_reg >= last_c) begin
                        ld_c_next = '0;
                        ld_r_next = (ld_r_reg >= last_r) ? '0 : ld_r_reg + RW'(1);
                    end else begin
                        ld_c_next = ld_c_reg + CW'(1);
                    end
                end else if (s_valid) begin
                    ld_r_next  = '0;
                    ld_c_next  = '0;
                    clr_r_next = '0;
                    clr_c_next = '0;
                    hctl.clear = 1'b1;
                    state_next = gea_pkg::S_CLR;
                end
            end
            gea_pkg::S_CLR: begin
                // sweep the used part of the visited map
                vis_we = 1'b1;
                if (clr_c_reg >= last_c) begin
                    clr_c_next = '0;
                    clr_r_next = clr_r_reg + RW'(1);
                    if (clr_r_reg >= last_r) begin
                        state_next = gea_pkg::S_CHK_A;
                    end
                end else begin
                    clr_c_next = clr_c_reg + CW'(1);
                end
            end
            gea_pkg::S_CHK_A: begin
                grid_ra    = lin_addr(RW'(0), CW'(1), ncols);
                state_next = gea_pkg::S_CHK_B;
            end
            gea_pkg::S_CHK_B: begin
                grid_ra    = lin_addr(RW'(1), CW'(0), ncols);
                chk_next   = grid_q;
                state_next = gea_pkg::S_CHK_C;
            end
            gea_pkg::S_CHK_C: begin
                // blocked start, else seed the heap with the start cell
                if (chk_reg > TIME_BITS'(1) && grid_q > TIME_BITS'(1)) begin
                    res_ok_next = 1'b0;
                    res_t_next  = '0;
                    state_next  = gea_pkg::S_DONE;
                end else begin
                    hctl.push  = 1'b1;
                    push_ent   = '0;
                    dir_next   = gea_pkg::DIR_LEFT;
                    state_next = gea_pkg::S_PUSH_W;
                end
            end
            gea_pkg::S_POP: begin
                if (hsts.empty) begin
                    res_ok_next = 1'b0;
                    res_t_next  = '0;
                    state_next  = gea_pkg::S_DONE;
                end else begin
                    hctl.pop   = 1'b1;
                    state_next = gea_pkg::S_POP_W;
                end
            end
            gea_pkg::S_POP_W: begin
                if (!hsts.busy) begin
                    ct_next = top_ent[ENT_W-1 -: TM_W];
                    cr_next = top_ent[GA_W-1 -: RW];
                    cc_next = top_ent[CW-1:0];
                    vis_ra  = top_ent[GA_W-1:0];
                    if (top_ent[GA_W-1:0] == {last_r, last_c}) begin
                        res_ok_next = 1'b1;
                        res_t_next  = (t_wide > SW'(gea_pkg::OUT_MAX)) ?
                                      gea_pkg::OUT_MAX : OW'(t_wide);
                        state_next  = gea_pkg::S_DONE;
                    end else begin
                        state_next = gea_pkg::S_VIS;
                    end
                end
            end
            gea_pkg::S_VIS: begin
                if (vis_q) begin
                    state_next = gea_pkg::S_POP;
                end else begin
                    vis_we     = 1'b1;
                    vis_wa     = {cr_reg, cc_reg};
                    vis_wd     = 1'b1;
                    dir_next   = gea_pkg::DIR_DOWN;
                    state_next = gea_pkg::S_NB;
                end
            end
            gea_pkg::S_NB: begin
                nr_next = nb_r;
                nc_next = nb_c;
                if (nb_ok) begin
                    state_next = gea_pkg::S_NB_CHK;
                end else if (dir_reg == gea_pkg::DIR_LEFT) begin
                    state_next = gea_pkg::S_POP;
                end else begin
                    dir_next = dir_reg + 2'd1;
                end
            end
            gea_pkg::S_NB_CHK: begin
                if (!vis_q) begin
                    hctl.push  = 1'b1;
                    state_next = gea_pkg::S_PUSH_W;
                end else if (dir_reg == gea_pkg::DIR_LEFT) begin
                    state_next = gea_pkg::S_POP;
                end else begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = gea_pkg::S_NB;
                end
            end
            gea_pkg::S_PUSH_W: begin
                if (!hsts.busy) begin
                    if (dir_reg == gea_pkg::DIR_LEFT) begin
                        state_next = gea_pkg::S_POP;
                    end else begin
                        dir_next   = dir_reg + 2'd1;
                        state_next = gea_pkg::S_NB;
                    end
                end
            end
            gea_pkg::S_DONE: begin
                // hand the result to the output register once it is free
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mr_next    = res_ok_reg;
                    mt_next    = res_t_reg;
                    state_next = gea_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = gea_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid     = mv_reg;
    assign m_reachable = mr_reg;
    assign m_min_time  = mt_reg;

endmodule

`default_nettype wire

FILE: sim/gea_scoreboard.sv
// gea_scoreboard: watches the cfg, s_ and m_ channels of the grid search unit,
// predicts each run's arrival time and compares it; depends on gea_pkg
`timescale 1ns / 100ps

module gea_scoreboard (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_valid,
    input  wire                           cfg_ready,
    input  wire [gea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [gea_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire                           s_valid,
    input  wire                           s_ready,
    input  wire                           s_func,
    input  wire [19:0]                    s_cell_time,
    input  wire                           m_valid,
    input  wire                           m_ready,
    input  wire                           m_reachable,
    input  wire [gea_pkg::OUT_W-1:0]      m_min_time,
    output int                            fail_count,
    output int                            pending
);

    localparam int GRID_MAX = 256;

    typedef struct {
        bit                        reachable;
        logic [gea_pkg::OUT_W-1:0] min_time;
    } arrival_t;

    logic [19:0]      cell_grid [GRID_MAX*GRID_MAX];
    logic [8:0]       rows_reg;
    logic [8:0]       cols_reg;
    int               load_ptr;
    arrival_t         arrivals_due [$];

    function automatic int clamp_dim(logic [8:0] v);
        if (v < 2) return 2;
        if (v > GRID_MAX) return GRID_MAX;
        return v;
    endfunction

    // earliest arrival at the bottom-right cell, waits padded to even length
    function automatic arrival_t predict_arrival();
        arrival_t res;
        int       m, n, total, u, r, c, nr, nc, v;
        longint   best_t[];
        bit       seen[];
        longint   arr, need, w;
        m = clamp_dim(rows_reg);
        n = clamp_dim(cols_reg);
        total = m * n;
        res.reachable = 0;
        res.min_time = '0;
        // start hemmed in by two slow neighbours
        if (cell_grid[1] > 1 && cell_grid[n] > 1) return res;
        best_t = new[total];
        seen = new[total];
        foreach (best_t[i]) best_t[i] = -1;
        best_t[0] = 0;
        forever begin
            u = -1;
            for (int i = 0; i < total; i++)
                if (!seen[i] && best_t[i] >= 0 && (u < 0 || best_t[i] < best_t[u])) u = i;
            if (u < 0) return res;
            if (u == total - 1) begin
                res.reachable = 1;
                res.min_time = (best_t[u] > gea_pkg::OUT_MAX) ?
                               gea_pkg::OUT_MAX : best_t[u][gea_pkg::OUT_W-1:0];
                return res;
            end
            seen[u] = 1;
            r = u / n;
            c = u % n;
            for (int k = 0; k < 4; k++) begin
                nr = r;
                nc = c;
                case (2'(k))
                    gea_pkg::DIR_DOWN:  nr = r + 1;
                    gea_pkg::DIR_UP:    nr = r - 1;
                    gea_pkg::DIR_RIGHT: nc = c + 1;
                    gea_pkg::DIR_LEFT:  nc = c - 1;
                    default: begin end
                endcase
                if (nr < 0 || nr >= m || nc < 0 || nc >= n) continue;
                v = nr * n + nc;
                if (seen[v]) continue;
                arr = best_t[u] + 1;
                need = cell_grid[v];
                if (arr < need) begin
                    w = need - arr;
                    if (w % 2) w++;
                    arr += w;
                end
                if (best_t[v] < 0 || arr < best_t[v]) best_t[v] = arr;
            end
        end
    endfunction

    // follow register writes and items, compare results in order
    always @(posedge aclk) begin
        arrival_t exp_a;
        int       total;
        if (!aresetn) begin
            rows_reg <= 9'd2;
            cols_reg <= 9'd2;
            load_ptr = 0;
            arrivals_due.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == gea_pkg::REG_ROWS) begin
                    rows_reg <= cfg_data;
                    load_ptr = 0;
                end else if (cfg_index == gea_pkg::REG_COLS) begin
                    cols_reg <= cfg_data;
                    load_ptr = 0;
                end
            end
            if (s_valid && s_ready) begin
                if (!s_func) begin
                    total = clamp_dim(rows_reg) * clamp_dim(cols_reg);
                    if (load_ptr >= total) load_ptr = 0;
                    cell_grid[load_ptr] = s_cell_time;
                    load_ptr++;
                    if (load_ptr >= total) load_ptr = 0;
                end else begin
                    load_ptr = 0;
                    arrivals_due.push_back(predict_arrival());
                end
            end
            if (m_valid && m_ready) begin
                if (arrivals_due.size() == 0) begin
                    $error("unexpected result item: reachable %0d min_time %0d",
                           m_reachable, m_min_time);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_a = arrivals_due.pop_front();
                    if (m_reachable !== exp_a.reachable || m_min_time !== exp_a.min_time)
                        fail_count <= fail_count + 1;
                    if (m_reachable !== exp_a.reachable)
                        $error("reachable: expected %0d, got %0d",
                               exp_a.reachable, m_reachable);
                    if (m_min_time !== exp_a.min_time)
                        $error("min_time: expected %0d, got %0d",
                               exp_a.min_time, m_min_time);
                end
            end
            pending <= arrivals_due.size();
        end
    end

endmodule

FILE: sim/tb_grid_earliest_arrival_dijkstra_unit.sv
// tb_grid_earliest_arrival_dijkstra_unit: stimulus and verdict for the grid search unit
// depends on gea_pkg, gea_scoreboard and grid_earliest_arrival_dijkstra_unit
`timescale 1ns / 100ps

module tb_grid_earliest_arrival_dijkstra_unit;

    localparam int CYCLE_LIMIT = 10000000;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    wire                            cfg_ready;
    logic [gea_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gea_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_valid;
    wire                            s_ready;
    logic                           s_func;
    logic [19:0]                    s_cell_time;
    wire                            m_valid;
    logic                           m_ready;
    wire                            m_reachable;
    wire  [gea_pkg::OUT_W-1:0]      m_min_time;
    int                             fail_count;
    int                             pending;

    int gap_pct;
    int stall_pct;
    int hold_off;
    int cycle_cnt;
    bit loaded [65536];
    int load_pos;
    int n_rows, n_cols;
    int item_cnt;

    grid_earliest_arrival_dijkstra_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_func(s_func), .s_cell_time(s_cell_time),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_reachable(m_reachable), .m_min_time(m_min_time)
    );

    gea_scoreboard checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_func(s_func), .s_cell_time(s_cell_time),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_reachable(m_reachable), .m_min_time(m_min_time),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random stalls plus an occasional long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 0;
        end else if (hold_off > 0) begin
            m_ready = 0;
            hold_off--;
        end else begin
            m_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // offer one item, keep valid high until accepted; entered and left at negedge
    task automatic send_item(bit f, logic [19:0] t);
        while ($urandom_range(99) < gap_pct) begin
            s_valid = 0;
            @(negedge aclk);
        end
        s_valid = 1;
        s_func = f;
        s_cell_time = t;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        item_cnt++;
    endtask

    task automatic load_cell(logic [19:0] t);
        send_item(0, t);
        loaded[load_pos] = 1;
        load_pos++;
        if (load_pos >= n_rows * n_cols) load_pos = 0;
    endtask

    task automatic start_run();
        send_item(1, 20'($urandom));
        load_pos = 0;
    endtask

    // write both dimensions once every result is back
    task automatic set_dims(int r, int c);
        s_valid = 0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        for (int k = 0; k < 2; k++) begin
            cfg_valid = 1;
            cfg_index = (k == 0) ? gea_pkg::REG_ROWS : gea_pkg::REG_COLS;
            cfg_data = (k == 0) ? 9'(r) : 9'(c);
            do @(posedge aclk); while (!cfg_ready);
            @(negedge aclk);
        end
        cfg_valid = 0;
        n_rows = (r < 2) ? 2 : (r > 256 ? 256 : r);
        n_cols = (c < 2) ? 2 : (c > 256 ? 256 : c);
        load_pos = 0;
    endtask

    function automatic logic [19:0] pick_time(int total);
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) return 0;
        if (sel < 15) return 20'($urandom);
        return 20'($urandom_range(2 * total + 4));
    endfunction

    // whole grid, optionally with the start walled in
    task automatic fill_grid(bit wall);
        int total;
        logic [19:0] t;
        total = n_rows * n_cols;
        for (int i = 0; i < total; i++) begin
            t = pick_time(total);
            if (wall && (load_pos == 1 || load_pos == n_cols))
                t = 20'($urandom_range(2, 40));
            load_cell(t);
        end
    endtask

    function automatic bit grid_ready();
        for (int i = 0; i < n_rows * n_cols; i++)
            if (!loaded[i]) return 0;
        return 1;
    endfunction

    // a full grid is only started while it still fits in the budget
    task automatic random_phase(int budget);
        int sel;
        int stop_at;
        stop_at = item_cnt + budget;
        while (item_cnt < stop_at) begin
            sel = $urandom_range(99);
            if (sel < 80 && stop_at - item_cnt > n_rows * n_cols) begin
                fill_grid($urandom_range(9) == 0);
                start_run();
            end else if (sel < 92) begin
                repeat ($urandom_range(1, 5)) load_cell(pick_time(n_rows * n_cols));
            end else if (grid_ready()) begin
                start_run();
            end
        end
    endtask

    task automatic set_idle(int mode);
        case (mode % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 55; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 55; end
            default: begin gap_pct = 11; stall_pct = 11; end
        endcase
    endtask

    initial begin
        aresetn = 0;
        cfg_valid = 0;
        cfg_index = gea_pkg::REG_ROWS;
        cfg_data = 0;
        s_valid = 0;
        s_func = 0;
        s_cell_time = 0;
        gap_pct = 0;
        stall_pct = 0;
        hold_off = 0;
        cycle_cnt = 0;
        item_cnt = 0;
        n_rows = 2;
        n_cols = 2;
        load_pos = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // directed: 2x2 grids after reset
        load_cell(0); load_cell(0); load_cell(0); load_cell(0);
        start_run();
        load_cell(20'hFFFFF); load_cell(20'hFFFFF); load_cell(1); load_cell(3);
        start_run();
        // start walled in
        load_cell(0); load_cell(2); load_cell(2); load_cell(0);
        start_run();
        // far corner only open very late
        load_cell(5); load_cell(0); load_cell(1); load_cell(20'hFFFFF);
        start_run();
        load_cell(20'h55555); load_cell(1); load_cell(20'hAAAAA); load_cell(4);
        start_run();

        // below-minimum, mid, and largest sizes in both dimensions
        set_dims(0, 1);    set_idle(1); random_phase(120);
        set_dims(3, 4);    set_idle(2); random_phase(140);
        set_dims(5, 5);    set_idle(0);
        hold_off = 600;
        random_phase(150);
        set_dims(511, 2);  set_idle(3); random_phase(520);
        set_dims(7, 3);    set_idle(1); random_phase(140);
        set_dims(2, 256);  set_idle(2); random_phase(520);
        set_dims(4, 8);    set_idle(0); random_phase(140);
        set_dims(1, 0);    set_idle(3); random_phase(100);

        // drain
        s_valid = 0;
        while (pending != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
